>>> design/sbh_pkg.sv
`timescale 1ns / 1ps
package sbh_pkg;
   localparam int unsigned TAP_WIDTH = 16;
   localparam int unsigned NUM_TAPS = 5;
   localparam int unsigned DISP_WIDTH = 16;
   localparam int unsigned PROB_WIDTH = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 3;

   localparam logic [TAP_WIDTH-1:0] TAP_RESET [NUM_TAPS] =
      '{16'd8825, 16'd8553, 16'd7788, 16'd6661, 16'd5352};

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_TAP_CENTER = 3'd0,
      CSR_TAP_ONE    = 3'd1,
      CSR_TAP_TWO    = 3'd2,
      CSR_TAP_THREE  = 3'd3,
      CSR_TAP_FOUR   = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_CLEAR,
      BK_SMOOTH,
      BK_DIVIDE,
      BK_TOTAL,
      BK_EMIT,
      BK_EMIT_DIV,
      BK_EMIT_OUT
   } back_state_type;

   // Status that the back end reports to the front end.
   typedef struct packed {
      logic busy;
      logic clear_done;
   } back_status_type;
endpackage

>>> design/sbh_if.sv
`timescale 1ns / 1ps
interface sbh_req_if #(parameter int unsigned DW = 16);
   logic          valid;
   logic          ready;
   logic [DW-1:0] disparity;
   logic          last_sample;
   modport source (output valid, disparity, last_sample, input ready);
   modport sink (input valid, disparity, last_sample, output ready);
endinterface

interface sbh_rsp_if #(parameter int unsigned IW = 6, parameter int unsigned CW = 20);
   logic          valid;
   logic          ready;
   logic [IW-1:0] bin_index;
   logic [CW-1:0] smoothed_count;
   logic [15:0]   probability;
   logic [CW-1:0] smoothed_total;
   logic [CW-1:0] sample_total;
   logic          last_bin;
   modport source (output valid, bin_index, smoothed_count, probability, smoothed_total,
                   sample_total, last_bin, input ready);
   modport sink (input valid, bin_index, smoothed_count, probability, smoothed_total,
                 sample_total, last_bin, output ready);
endinterface

>>> design/sbh_divider.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module sbh_divider
   import sbh_pkg::*;
#(
   parameter int unsigned NW = 56,
   parameter int unsigned DW = 36
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] numer,
   input  logic [DW-1:0] denom,
   output logic          done,
   output logic [NW-1:0] quot,
   output logic [DW-1:0] rem
);
   localparam int unsigned CNT_W = $clog2(NW + 1);

   logic [NW-1:0]    quot_ff, quot_in;
   logic [DW:0]      rem_ff, rem_in;
   logic [DW-1:0]    den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DW:0]      trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DW-1:0], quot_ff[NW-1]};
      if (start) begin
         quot_in = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = CNT_W'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = trial - {1'b0, den_ff};
            quot_in = {quot_ff[NW-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff[DW-1:0];

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff) else $error("divider did not start");
   a_busy_cnt: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0) else $error("divider busy with zero count");
endmodule

>>> design/sbh_front.sv
`timescale 1ns / 1ps
// Accepts samples, computes the bin and queues count updates.
module sbh_front
   import sbh_pkg::*;
#(
   parameter int unsigned NUM_BINS = 64,
   parameter int unsigned COUNT_WIDTH = 20
) (
   input  logic                        clock,
   input  logic                        reset,
   sbh_req_if.sink                     req,
   input  back_status_type             status,
   input  logic                        q_pop,
   output logic                        q_valid,
   output logic                        q_counted,
   output logic [$clog2(NUM_BINS)-1:0] q_bin,
   output logic                        q_last,
   output logic [COUNT_WIDTH-1:0]      pixel_total
);
   localparam int unsigned BW = $clog2(NUM_BINS);
   localparam int unsigned QD = 4;
   localparam int unsigned QW = $clog2(QD);
   localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

   logic [BW-1:0]          qb_ff [QD];
   logic                   qc_ff [QD];
   logic                   ql_ff [QD];
   logic [QW-1:0]          wp_ff, rp_ff;
   logic [QW:0]            cnt_ff, cnt_in;
   logic                   hold_ff, hold_in;
   logic [COUNT_WIDTH-1:0] pix_ff, pix_in;
   logic                   accept, pop_ok;
   logic [DISP_WIDTH+BW-1:0] prod;

   // No new samples once a set end is queued until the back end finishes.
   assign req.ready = !hold_ff && !status.busy && status.clear_done && (cnt_ff < (QW+1)'(QD));
   assign accept    = req.valid && req.ready;
   assign pop_ok    = q_pop && (cnt_ff != '0);
   assign prod      = {{BW{1'b0}}, req.disparity} << BW;

   always_comb begin
      cnt_in  = cnt_ff + (QW+1)'(accept) - (QW+1)'(pop_ok);
      hold_in = hold_ff;
      pix_in  = pix_ff;
      if (accept) begin
         if (pix_ff != CMAX) pix_in = pix_ff + 1'b1;
         if (req.last_sample) hold_in = 1'b1;
      end
      // The back end has taken the sample total with the set end.
      if (pop_ok && ql_ff[rp_ff]) begin
         hold_in = 1'b0;
         pix_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         cnt_ff  <= '0;
         hold_ff <= 1'b0;
         pix_ff  <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         hold_ff <= hold_in;
         pix_ff  <= pix_in;
         if (accept) wp_ff <= wp_ff + 1'b1;
         if (pop_ok) rp_ff <= rp_ff + 1'b1;
      end
      if (accept) begin
         qb_ff[wp_ff] <= prod[DISP_WIDTH-1 +: BW];
         qc_ff[wp_ff] <= !req.disparity[DISP_WIDTH-1];
         ql_ff[wp_ff] <= req.last_sample;
      end
   end

   assign q_valid     = cnt_ff != '0;
   assign q_bin       = qb_ff[rp_ff];
   assign q_counted   = qc_ff[rp_ff];
   assign q_last      = ql_ff[rp_ff];
   assign pixel_total = pix_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QW+1)'(QD)) else $error("queue overflow");
   a_hold_blocks: assert property (@(posedge clock) disable iff (reset)
      hold_ff |-> !accept) else $error("sample taken after set end");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
endmodule

>>> design/sbh_back.sv
`timescale 1ns / 1ps
// Counts bins, and at set end smooths, totals, emits one result per bin and clears the counts.
module sbh_back
   import sbh_pkg::*;
#(
   parameter int unsigned NUM_BINS = 64,
   parameter int unsigned FILTER_RADIUS = 4,
   parameter int unsigned COUNT_WIDTH = 20
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [TAP_WIDTH-1:0]        taps [NUM_TAPS],
   input  logic                        q_valid,
   input  logic                        q_counted,
   input  logic [$clog2(NUM_BINS)-1:0] q_bin,
   input  logic                        q_last,
   output logic                        q_pop,
   input  logic [COUNT_WIDTH-1:0]      pixel_total,
   output back_status_type             status,
   sbh_rsp_if.source                   rsp
);
   localparam int unsigned BW  = $clog2(NUM_BINS);
   localparam int unsigned TW  = $clog2(2*FILTER_RADIUS + 1);
   localparam int unsigned WW  = TAP_WIDTH + 4;
   localparam int unsigned VW  = TAP_WIDTH + COUNT_WIDTH + 4;
   localparam int unsigned NW  = (VW > COUNT_WIDTH + 16) ? VW : COUNT_WIDTH + 16;
   localparam int unsigned DVW = (WW > COUNT_WIDTH) ? WW : COUNT_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
   localparam logic [BW-1:0] LAST_BIN = BW'(NUM_BINS - 1);

   logic [COUNT_WIDTH-1:0] cnt_mem [NUM_BINS];
   logic [COUNT_WIDTH-1:0] sm_mem [NUM_BINS];

   back_state_type st_ff, st_in;
   logic [BW-1:0]  bin_ff, bin_in;
   logic [TW-1:0]  tap_ff, tap_in;
   logic [VW-1:0]  v_ff, v_in;
   logic [WW-1:0]  w_ff, w_in;
   logic [COUNT_WIDTH-1:0] tot_ff, tot_in;
   logic [COUNT_WIDTH-1:0] sm_rd_ff, cnt_rd_ff;
   logic           rd_ok_ff, rd_ok_in;
   logic [TAP_WIDTH-1:0] rd_tap_ff, rd_tap_in;
   logic           clr_done_ff, clr_done_in;
   logic           upd_ff;
   logic [BW-1:0]  upd_bin_ff;
   logic [COUNT_WIDTH-1:0] upd_val;
   logic           ov_ff;
   logic [BW-1:0]  ob_ff;
   logic [COUNT_WIDTH-1:0] os_ff, ot_ff, opx_ff;
   logic [PROB_WIDTH-1:0]  op_ff;
   logic           ol_ff;
   logic [COUNT_WIDTH-1:0] px_ff, px_in;
   logic           load_out;

   logic           cnt_we, sm_we;
   logic [BW-1:0]  cnt_wa, cnt_ra, sm_ra;
   logic [COUNT_WIDTH-1:0] cnt_wd, sm_wd;

   logic [BW:0]    j_wide;
   logic           j_ok;
   logic [TW-1:0]  tap_dist;

   logic           dv_start, dv_done;
   logic [NW-1:0]  dv_num, dv_q;
   logic [DVW-1:0] dv_den, dv_r;
   logic [DVW:0]   twice_r;
   logic [NW-1:0]  q_rnd;

   sbh_divider #(.NW(NW), .DW(DVW)) u_div (
      .clock, .reset, .start(dv_start), .numer(dv_num), .denom(dv_den),
      .done(dv_done), .quot(dv_q), .rem(dv_r)
   );

   // Neighbor at offset tap_ff - R of bin_ff.
   assign j_wide = {1'b0, bin_ff} + (BW+1)'(tap_ff) - (BW+1)'(FILTER_RADIUS);
   assign j_ok   = (({1'b0, bin_ff} + (BW+1)'(tap_ff)) >= (BW+1)'(FILTER_RADIUS)) &&
                   (j_wide < (BW+1)'(NUM_BINS));
   assign tap_dist = (tap_ff >= TW'(FILTER_RADIUS)) ? tap_ff - TW'(FILTER_RADIUS)
                                                    : TW'(FILTER_RADIUS) - tap_ff;
   assign twice_r = {dv_r, 1'b0};
   assign upd_val = (cnt_rd_ff == CMAX) ? CMAX : cnt_rd_ff + 1'b1;

   always_comb begin
      st_in       = st_ff;
      bin_in      = bin_ff;
      tap_in      = tap_ff;
      v_in        = v_ff;
      w_in        = w_ff;
      tot_in      = tot_ff;
      rd_ok_in    = 1'b0;
      rd_tap_in   = (32'(tap_dist) < NUM_TAPS) ? taps[3'(tap_dist)] : '0;
      clr_done_in = clr_done_ff;
      px_in       = px_ff;
      q_pop       = 1'b0;
      cnt_we      = 1'b0;
      cnt_wa      = bin_ff;
      cnt_wd      = '0;
      cnt_ra      = q_bin;
      sm_we       = 1'b0;
      sm_wd       = '0;
      sm_ra       = bin_ff;
      dv_start    = 1'b0;
      dv_num      = NW'(v_ff);
      dv_den      = DVW'(w_ff);
      load_out    = 1'b0;
      q_rnd       = dv_q;
      if (twice_r > {1'b0, dv_den} || (twice_r == {1'b0, dv_den} && dv_q[0]))
         q_rnd = dv_q + 1'b1;
      unique case (st_ff)
         BK_IDLE: begin
            // Increment pipeline: read now, write next cycle; stall on a hazard.
            if (q_valid && !(upd_ff && upd_bin_ff == q_bin)) begin
               q_pop = 1'b1;
               if (q_last) begin
                  st_in  = BK_SMOOTH;
                  px_in  = pixel_total;
                  bin_in = '0;
                  tap_in = '0;
                  v_in   = '0;
                  w_in   = '0;
                  tot_in = '0;
               end
            end
         end
         BK_CLEAR: begin
            cnt_we = 1'b1;
            cnt_wa = bin_ff;
            bin_in = bin_ff + 1'b1;
            if (bin_ff == LAST_BIN) begin
               st_in       = BK_IDLE;
               clr_done_in = 1'b1;
               bin_in      = '0;
            end
         end
         BK_SMOOTH: begin
            // One tap per cycle while no count update is pending; the count used
            // was read in the previous cycle. The extra step after the last tap folds
            // in its product and starts the divide.
            cnt_ra = BW'(j_wide);
            if (rd_ok_ff) begin
               v_in = v_ff + VW'(rd_tap_ff) * VW'(cnt_rd_ff);
               w_in = w_ff + WW'(rd_tap_ff);
            end
            if (tap_ff == TW'(2*FILTER_RADIUS + 1)) begin
               dv_start = 1'b1;
               dv_num   = NW'(v_in);
               dv_den   = DVW'(w_in);
               st_in    = BK_DIVIDE;
            end else if (!upd_ff) begin
               rd_ok_in = j_ok && (32'(tap_dist) < NUM_TAPS);
               tap_in   = tap_ff + 1'b1;
            end
         end
         BK_DIVIDE: begin
            if (dv_done) begin
               sm_we = 1'b1;
               if (w_ff == '0) sm_wd = '0;
               else if (q_rnd > NW'(CMAX)) sm_wd = CMAX;
               else sm_wd = COUNT_WIDTH'(q_rnd);
               tot_in = ((COUNT_WIDTH+1)'(tot_ff) + (COUNT_WIDTH+1)'(sm_wd) >
                         (COUNT_WIDTH+1)'(CMAX)) ? CMAX : tot_ff + sm_wd;
               v_in   = '0;
               w_in   = '0;
               tap_in = '0;
               if (bin_ff == LAST_BIN) begin
                  st_in  = BK_TOTAL;
                  bin_in = '0;
               end else begin
                  st_in  = BK_SMOOTH;
                  bin_in = bin_ff + 1'b1;
               end
            end
         end
         BK_TOTAL: begin
            sm_ra = '0;
            st_in = BK_EMIT;
         end
         BK_EMIT: begin
            // sm_rd_ff holds the smoothed count of bin_ff.
            if (tot_ff == '0) begin
               st_in = BK_EMIT_OUT;
            end else begin
               dv_start = 1'b1;
               dv_num   = NW'({sm_rd_ff, 16'h0000});
               dv_den   = DVW'(tot_ff);
               st_in    = BK_EMIT_DIV;
            end
         end
         BK_EMIT_DIV: begin
            dv_num = '0;
            dv_den = DVW'(tot_ff);
            if (dv_done) st_in = BK_EMIT_OUT;
         end
         BK_EMIT_OUT: begin
            if (!ov_ff || rsp.ready) begin
               load_out = 1'b1;
               sm_ra    = bin_ff + 1'b1;
               if (bin_ff == LAST_BIN) begin
                  st_in       = BK_CLEAR;
                  bin_in      = '0;
                  clr_done_in = 1'b0;
               end else begin
                  st_in  = BK_EMIT;
                  bin_in = bin_ff + 1'b1;
               end
            end
         end
         default: st_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= BK_CLEAR;
         bin_ff      <= '0;
         tap_ff      <= '0;
         rd_ok_ff    <= 1'b0;
         clr_done_ff <= 1'b0;
         upd_ff      <= 1'b0;
         ov_ff       <= 1'b0;
      end else begin
         st_ff       <= st_in;
         bin_ff      <= bin_in;
         tap_ff      <= tap_in;
         rd_ok_ff    <= rd_ok_in;
         clr_done_ff <= clr_done_in;
         upd_ff      <= q_pop && q_counted;
         if (load_out) ov_ff <= 1'b1;
         else if (rsp.ready) ov_ff <= 1'b0;
      end
      v_ff       <= v_in;
      w_ff       <= w_in;
      tot_ff     <= tot_in;
      px_ff      <= px_in;
      rd_tap_ff  <= rd_tap_in;
      upd_bin_ff <= q_bin;
      cnt_rd_ff  <= cnt_mem[cnt_ra];
      sm_rd_ff   <= sm_mem[sm_ra];
      if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
      else if (upd_ff) cnt_mem[upd_bin_ff] <= upd_val;
      if (sm_we) sm_mem[bin_ff] <= sm_wd;
      if (load_out) begin
         ob_ff  <= bin_ff;
         os_ff  <= sm_rd_ff;
         op_ff  <= (tot_ff == '0) ? '0 :
                   (dv_q > NW'(16'hFFFF)) ? 16'hFFFF : PROB_WIDTH'(dv_q);
         ot_ff  <= tot_ff;
         opx_ff <= px_ff;
         ol_ff  <= (bin_ff == LAST_BIN);
      end
   end

   // Status for the front end.
   always_comb begin
      status.busy       = (st_ff != BK_IDLE);
      status.clear_done = clr_done_ff;
   end

   assign rsp.valid          = ov_ff;
   assign rsp.bin_index      = ob_ff;
   assign rsp.smoothed_count = os_ff;
   assign rsp.probability    = op_ff;
   assign rsp.smoothed_total = ot_ff;
   assign rsp.sample_total   = opx_ff;
   assign rsp.last_bin       = ol_ff;

   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      ov_ff && !rsp.ready |=> ov_ff) else $error("result dropped");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> st_ff == BK_IDLE) else $error("queue popped while busy");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load_out |-> (!ov_ff || rsp.ready)) else $error("result overwritten");
endmodule

>>> design/smoothed_bin_histogram.sv
`timescale 1ns / 1ps
// Smoothed disparity histogram.
// Samples arrive on the req channel, one transaction per cycle while the
// block is counting and its queue has room: each non-negative disparity
// increments its bin, and every sample counts toward sample_total. Two
// counted samples in a row that hit the same bin stall the back end, so a
// long run of them slows acceptance once the four-entry queue is full. A
// transaction with last_sample set closes the set. The back end then smooths
// every bin with the nine-tap Gaussian from the csr taps: nine tap reads, a
// step that folds in the last product and starts the divide, and a 40-step
// sequential divide. It then emits one rsp transaction per bin, bin 0 first,
// each needing another divide for the probability unless the smoothed total
// is zero. The first result comes only after every bin is smoothed and the
// total is formed; the smoothing and probability divides share the single
// divider. While the pass runs, req.ready is low. After the pass the bin
// store is cleared; the same clearing pass runs after reset before the first
// sample is taken.
// If the receiver stalls rsp, the result register holds and the pass waits.
// Taps are written through csr_*, by the user only at idle time, which the
// block does not enforce; reset loads defaults.
module smoothed_bin_histogram
   import sbh_pkg::*;
#(
   parameter int unsigned NUM_BINS = 64,
   parameter int unsigned FILTER_RADIUS = 4,
   parameter int unsigned COUNT_WIDTH = 20
) (
   input  logic                       clock,
   input  logic                       reset,
   sbh_req_if.sink                    req,
   sbh_rsp_if.source                  rsp,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [TAP_WIDTH-1:0]       csr_data
);
   localparam int unsigned BW = $clog2(NUM_BINS);

   logic [TAP_WIDTH-1:0] tap_ff [NUM_TAPS];
   back_status_type      status;
   logic                 q_valid, q_counted, q_last, q_pop;
   logic [BW-1:0]        q_bin;
   logic [COUNT_WIDTH-1:0] pixel_total;

   // Tap registers; out-of-range indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff <= TAP_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TAP_CENTER: tap_ff[0] <= csr_data;
            CSR_TAP_ONE:    tap_ff[1] <= csr_data;
            CSR_TAP_TWO:    tap_ff[2] <= csr_data;
            CSR_TAP_THREE:  tap_ff[3] <= csr_data;
            CSR_TAP_FOUR:   tap_ff[4] <= csr_data;
            default: ;
         endcase
      end
   end

   sbh_front #(.NUM_BINS(NUM_BINS), .COUNT_WIDTH(COUNT_WIDTH)) u_front (
      .clock, .reset, .req, .status, .q_pop, .q_valid, .q_counted,
      .q_bin, .q_last, .pixel_total
   );

   sbh_back #(.NUM_BINS(NUM_BINS), .FILTER_RADIUS(FILTER_RADIUS),
              .COUNT_WIDTH(COUNT_WIDTH)) u_back (
      .clock, .reset, .taps(tap_ff), .q_valid, .q_counted, .q_bin, .q_last,
      .q_pop, .pixel_total, .status, .rsp
   );

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      status.busy |-> !req.ready) else $error("sample taken during pass");
   a_rsp_only_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> status.busy) else $error("result outside pass");
   a_ready_clear: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> status.clear_done) else $error("ready before clear");
endmodule
